@@ rtl/zlenc_pkg.sv @@
`default_nettype none
// ============================================================================
// zlenc_pkg
// Shared types and constants of the compact list entry encoder.
// ============================================================================
package zlenc_pkg;

    // Width of the saturated string length.
    localparam int LENGTH_BITS = 30;

    // Serialized bytes per queued request, at most.
    localparam int MAX_BYTES = 14;
    localparam int NUM_W     = 4;

    // Command codes.
    localparam logic [1:0] CMD_INT  = 2'd0;
    localparam logic [1:0] CMD_STR  = 2'd1;
    localparam logic [1:0] CMD_BYTE = 2'd2;

    // Status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ORDER = 1'b1;

    // Previous-entry-length field.
    localparam logic [30:0] PREV_LIMIT = 31'd254;
    localparam logic [7:0]  PREV_BIG   = 8'hFE;

    // Integer encodings.
    localparam logic [7:0] IMM_BASE  = 8'hF1;
    localparam logic [7:0] ENC_INT8  = 8'hFE;
    localparam logic [7:0] ENC_INT16 = 8'hC0;
    localparam logic [7:0] ENC_INT24 = 8'hF0;
    localparam logic [7:0] ENC_INT32 = 8'hD0;
    localparam logic [7:0] ENC_INT64 = 8'hE0;

    // String length headers.
    localparam logic [31:0] STR6_MAX  = 32'h3F;
    localparam logic [31:0] STR14_MAX = 32'h3FFF;
    localparam logic [7:0]  ENC_STR14 = 8'h40;
    localparam logic [7:0]  ENC_STR32 = 8'h80;

    // List header size and counter limits.
    localparam logic [31:0] HEADER_BYTES = 32'd10;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    // One queued request: its bytes in emission order and the results' fields.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [NUM_W-1:0]          num;
        logic                      status;
        logic [31:0]               list_bytes;
        logic [15:0]               entry_count;
        logic [31:0]               tail_offset;
    } entry_t;

endpackage
`default_nettype wire

@@ rtl/zlenc_front.sv @@
`default_nettype none
// ============================================================================
// zlenc_front
// Accepts requests, classifies them and updates the list counters; builds the
// complete byte sequence of each request for the serializer.
// ============================================================================
module zlenc_front import zlenc_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire logic [1:0]             in_command,
    input  wire logic signed [63:0]     in_int_value,
    input  wire logic [29:0]            in_string_length,
    input  wire logic [7:0]             in_data_byte,
    output entry_t                      push_entry
);

    localparam logic [29:0] STR_MAX = 30'((64'd1 << LENGTH_BITS) - 64'd1);

    logic [30:0]            len_reg,   len_next;
    logic [31:0]            total_reg, total_next;
    logic [15:0]            count_reg, count_next;
    logic [31:0]            tail_reg,  tail_next;
    logic [LENGTH_BITS-1:0] left_reg,  left_next;
    logic                   open_reg,  open_next;

    logic                   accept;
    logic                   begin_ok;
    logic                   pay_ok;
    logic                   prev_small;
    logic [4:0][7:0]        prev_bytes;
    logic [8:0][7:0]        body;
    logic [NUM_W-1:0]       body_num;
    logic [NUM_W-1:0]       num;
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [63:0]            u;
    logic [29:0]            len_sat;
    logic [LENGTH_BITS-1:0] len;
    logic [31:0]            len32;
    logic [32:0]            tail_sum;
    logic [32:0]            total_sum;
    logic [15:0]            count_inc;
    logic [31:0]            tail_new;
    logic                   fits8, fits16, fits24, fits32, is_imm;

    assign accept   = in_valid && in_ready;
    assign begin_ok = (in_command == CMD_INT || in_command == CMD_STR) && !open_reg;
    assign pay_ok   = (in_command == CMD_BYTE) && open_reg;

    // Previous-entry-length field.
    assign prev_small = len_reg < PREV_LIMIT;
    assign prev_bytes = {1'b0, len_reg[30:24], len_reg[23:16], len_reg[15:8], len_reg[7:0],
                         prev_small ? len_reg[7:0] : PREV_BIG};

    // Integer range classification by sign extension of the upper bits.
    assign u      = in_int_value;
    assign is_imm = (~|u[63:4]) && (u[3:0] <= 4'd12);
    assign fits8  = (&u[63:7])  || (~|u[63:7]);
    assign fits16 = (&u[63:15]) || (~|u[63:15]);
    assign fits24 = (&u[63:23]) || (~|u[63:23]);
    assign fits32 = (&u[63:31]) || (~|u[63:31]);

    // String length, saturated to the configured width.
    assign len_sat = (in_string_length > STR_MAX) ? STR_MAX : in_string_length;
    assign len     = len_sat[LENGTH_BITS-1:0];
    assign len32   = {{(32-LENGTH_BITS){1'b0}}, len};

    // Encoding body that follows the previous-entry-length field.
    always_comb begin
        body     = '0;
        body_num = '0;
        if (in_command == CMD_INT) begin
            body[8:1] = u;
            if (is_imm) begin
                body[0]  = IMM_BASE + {4'd0, u[3:0]};
                body_num = 4'd1;
            end else if (fits8) begin
                body[0]  = ENC_INT8;
                body_num = 4'd2;
            end else if (fits16) begin
                body[0]  = ENC_INT16;
                body_num = 4'd3;
            end else if (fits24) begin
                body[0]  = ENC_INT24;
                body_num = 4'd4;
            end else if (fits32) begin
                body[0]  = ENC_INT32;
                body_num = 4'd5;
            end else begin
                body[0]  = ENC_INT64;
                body_num = 4'd9;
            end
        end else begin
            if (len32 <= STR6_MAX) begin
                body[0]  = len32[7:0];
                body_num = 4'd1;
            end else if (len32 <= STR14_MAX) begin
                body[0]  = ENC_STR14 | {2'b00, len32[13:8]};
                body[1]  = len32[7:0];
                body_num = 4'd2;
            end else begin
                body[0]  = ENC_STR32;
                body[1]  = len32[31:24];
                body[2]  = len32[23:16];
                body[3]  = len32[15:8];
                body[4]  = len32[7:0];
                body_num = 4'd5;
            end
        end
    end

    // Assemble the sequence of an entry start.
    always_comb begin
        if (prev_small) begin
            bytes = {{((MAX_BYTES - 10) * 8){1'b0}}, body, prev_bytes[0]};
        end else begin
            bytes = {body, prev_bytes};
        end
        num = (prev_small ? 4'd1 : 4'd5) + body_num;
    end

    // Counter updates of an entry start.
    assign tail_sum  = {1'b0, tail_reg} + {2'b00, len_reg};
    assign tail_new  = tail_sum[32] ? 32'hFFFF_FFFF : tail_sum[31:0];
    assign count_inc = (count_reg < COUNT_MAX) ? count_reg + 16'd1 : count_reg;

    always_comb begin
        len_next   = len_reg;
        count_next = count_reg;
        tail_next  = tail_reg;
        left_next  = left_reg;
        open_next  = open_reg;
        push_entry = '0;
        total_sum  = {1'b0, total_reg};
        if (begin_ok) begin
            count_next       = count_inc;
            tail_next        = tail_new;
            push_entry.bytes = bytes;
            push_entry.num   = num;
            total_sum        = {1'b0, total_reg} + {29'd0, num};
            if (in_command == CMD_INT) begin
                len_next = {27'd0, num};
            end else begin
                len_next  = {27'd0, num} + {{(31-LENGTH_BITS){1'b0}}, len};
                left_next = len;
                open_next = |len;
            end
        end else if (pay_ok) begin
            push_entry.bytes[0] = in_data_byte;
            push_entry.num      = 4'd1;
            total_sum           = {1'b0, total_reg} + 33'd1;
            left_next           = left_reg - LENGTH_BITS'(1);
            open_next           = |left_next;
        end else begin
            push_entry.num    = 4'd1;
            push_entry.status = STATUS_ORDER;
        end
        total_next = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
        push_entry.list_bytes  = total_next;
        push_entry.entry_count = count_next;
        push_entry.tail_offset = tail_next;
    end

    // Architectural state of the list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            total_reg <= HEADER_BYTES;
            count_reg <= '0;
            tail_reg  <= HEADER_BYTES;
            left_reg  <= '0;
            open_reg  <= 1'b0;
        end else if (accept) begin
            len_reg   <= len_next;
            total_reg <= total_next;
            count_reg <= count_next;
            tail_reg  <= tail_next;
            left_reg  <= left_next;
            open_reg  <= open_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/zlenc_fifo.sv @@
`default_nettype none
// ============================================================================
// zlenc_fifo
// Two-entry queue of built requests between the front end and the serializer.
// ============================================================================
module zlenc_fifo import zlenc_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  entry_t      push_entry,
    input  wire logic   pop,
    output entry_t      head_entry,
    output logic        head_valid,
    output logic        full,
    output logic [1:0]  level
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] level_reg,  level_next;

    assign head_entry = mem_reg[rd_ptr_reg];
    assign head_valid = level_reg != 2'd0;
    assign full       = level_reg == 2'd2;
    assign level      = level_reg;

    // Pointer and fill level bookkeeping.
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        level_next  = level_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

@@ rtl/zlenc_back.sv @@
`default_nettype none
// ============================================================================
// zlenc_back
// Serializer: walks the head request one byte per cycle, unless out_ready
// stalls, into the output register; releases it after its final byte.
// ============================================================================
module zlenc_back import zlenc_pkg::*; (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  entry_t      head_entry,
    input  wire logic   head_valid,
    output logic        pop,
    input  wire logic   out_ready,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        out_status,
    output logic [31:0] out_list_bytes,
    output logic [15:0] out_entry_count,
    output logic [31:0] out_tail_offset
);

    logic [NUM_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             status_reg;
    logic [31:0]      list_reg;
    logic [15:0]      count_reg;
    logic [31:0]      tail_reg;
    logic             load;
    logic             is_last;

    // Load a waiting request's byte when the output register is empty or draining.
    assign load    = head_valid && (!valid_reg || out_ready);
    assign is_last = idx_reg == head_entry.num - NUM_W'(1);
    assign pop     = load && is_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            idx_next   = is_last ? '0 : idx_reg + NUM_W'(1);
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg   <= head_entry.bytes[idx_reg];
            last_reg   <= is_last;
            status_reg <= head_entry.status;
            list_reg   <= head_entry.list_bytes;
            count_reg  <= head_entry.entry_count;
            tail_reg   <= head_entry.tail_offset;
        end
    end

    assign out_valid       = valid_reg;
    assign out_byte        = byte_reg;
    assign out_last        = last_reg;
    assign out_status      = status_reg;
    assign out_list_bytes  = list_reg;
    assign out_entry_count = count_reg;
    assign out_tail_offset = tail_reg;

endmodule
`default_nettype wire

@@ rtl/ziplist_entry_encoder_unit.sv @@
// The first result byte of a request passes through the queue and the output register.
// Throughput: one request per cycle while each request yields one byte and m_ready is
// high; a longer request holds the serializer until its final byte, one byte at a time.
// A two-entry queue lets the front accept while the serializer is busy or stalled.
// Reset (aresetn, synchronous, active low) empties the queue and output register and
// restores the list counters to an empty list (10 header bytes, no entries).
`default_nettype none
// ============================================================================
// ziplist_entry_encoder_unit
// Compact list entry encoder: front end, request queue and byte serializer.
// ============================================================================
module ziplist_entry_encoder_unit import zlenc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_command,
    input  wire logic signed [63:0] s_int_value,
    input  wire logic [29:0]        s_string_length,
    input  wire logic [7:0]         s_data_byte,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_out_byte,
    output logic                    m_last,
    output logic                    m_status,
    output logic [31:0]             m_list_bytes,
    output logic [15:0]             m_entry_count,
    output logic [31:0]             m_tail_offset
);

    entry_t     push_entry;
    entry_t     head_entry;
    logic       head_valid;
    logic       full;
    logic       pop;
    logic       push;
    logic [1:0] level;

    assign s_ready = !full;
    assign push    = s_valid && s_ready;

    // Request classification and counter update.
    zlenc_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_valid),
        .in_ready         (s_ready),
        .in_command       (s_command),
        .in_int_value     (s_int_value),
        .in_string_length (s_string_length),
        .in_data_byte     (s_data_byte),
        .push_entry       (push_entry)
    );

    // Queue between front end and serializer.
    zlenc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .head_valid (head_valid),
        .full       (full),
        .level      (level)
    );

    // Byte serializer with output register.
    zlenc_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_entry      (head_entry),
        .head_valid      (head_valid),
        .pop             (pop),
        .out_ready       (m_ready),
        .out_valid       (m_valid),
        .out_byte        (m_out_byte),
        .out_last        (m_last),
        .out_status      (m_status),
        .out_list_bytes  (m_list_bytes),
        .out_entry_count (m_entry_count),
        .out_tail_offset (m_tail_offset)
    );

`ifndef SYNTH
    // An ignored request yields exactly one result.
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> m_last)
        else $error("rejected request result not marked last");

    // An ignored request carries a zero byte.
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> (m_out_byte == 8'd0))
        else $error("rejected request result carries data");

    // The queue never holds more than two requests.
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        level != 2'd3)
        else $error("request queue overflow");

    // A request accepted into an empty queue reaches the serializer next cycle.
    a_push_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && level == 2'd0) |=> head_valid)
        else $error("accepted request lost");
`endif

endmodule
`default_nettype wire
